// File: rtl/core/hspl_pkg.sv
// Package for the hash-to-small-polynomial sampler: sponge constants,
// function and register codes, and the structs between the core and its units.
// Depends on nothing.
`timescale 1ns / 1ps

package hspl_pkg;

	localparam logic [63:0] SEED_WORD    = 64'h243F6A8885A308D3;
	localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_C1       = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_C2       = 64'h94D049BB133111EB;
	localparam logic [31:0] LANE_WORD    = 32'h9E3779B1;
	localparam logic [31:0] LANE_COEFF   = 32'h85EBCA6B;
	localparam logic [31:0] LANE_BYTE    = 32'hC2B2AE35;
	localparam logic [31:0] TAG_WORD     = 32'h48655F65;

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_COEFF = 2'd1;
	localparam logic [1:0] FUNC_BYTE  = 2'd2;
	localparam logic [1:0] FUNC_DRAW  = 2'd3;

	localparam logic [1:0] CFG_RING_DEGREE = 2'd0;
	localparam logic [1:0] CFG_MODULUS     = 2'd1;
	localparam logic [1:0] CFG_COEFF_BOUND = 2'd2;

	localparam logic [15:0] RING_DEGREE_RST = 16'd509;
	localparam logic [15:0] MODULUS_RST     = 16'd2048;
	localparam logic [7:0]  COEFF_BOUND_RST = 8'd1;
	localparam logic [16:0] LIMIT_RST       = 17'd65535;
	localparam logic [16:0] WORD_SPAN       = 17'h10000;

	localparam int REM_W  = 17;
	localparam int REM_CW = $clog2(REM_W);

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
	} mul_op_t;

	typedef struct packed {
		logic             go;
		logic [REM_W-1:0] dividend;
		logic [REM_W-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [REM_W-1:0] remainder;
	} rem_rsp_t;

endpackage

// File: rtl/core/hspl_if.sv
// Handshake channels of the sampler: input items, result items, register writes.
// Depends on hspl_pkg.
`timescale 1ns / 1ps

interface hspl_item_if import hspl_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] value;
	modport source(output valid, func, value, input ready);
	modport sink(input valid, func, value, output ready);
endinterface

interface hspl_res_if import hspl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic signed [8:0] small_coeff;
	logic [15:0]       residue_coeff;
	modport source(output valid, small_coeff, residue_coeff, input ready);
	modport sink(input valid, small_coeff, residue_coeff, output ready);
endinterface

interface hspl_cfg_if import hspl_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/core/hash_to_small_poly_sampler.sv
// Absorb item: one product, then two mixing rounds. Start item: four absorbs plus
// a 17-step remainder for the reject limit. Draw item: two mixing rounds per candidate
// word, redrawn while rejected, plus two 17-step remainders; one item at a time.
// All products go through one shared 32x32 multiplier: absorb in one pass, each 64-bit mix product in 3.
// Reset: sponge to seed, registers to defaults, reject limit 65535, no result.
`timescale 1ns / 1ps

module hash_to_small_poly_sampler import hspl_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	hspl_item_if.sink   item,
	hspl_res_if.source  result,
	hspl_cfg_if.sink    cfg
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MULV = 4'd1;
	localparam logic [3:0] ST_PREP = 4'd2;
	localparam logic [3:0] ST_M0   = 4'd3;
	localparam logic [3:0] ST_M1   = 4'd4;
	localparam logic [3:0] ST_M2   = 4'd5;
	localparam logic [3:0] ST_M3   = 4'd6;
	localparam logic [3:0] ST_LIM  = 4'd7;
	localparam logic [3:0] ST_LIMW = 4'd8;
	localparam logic [3:0] ST_RM   = 4'd9;
	localparam logic [3:0] ST_RMW  = 4'd10;
	localparam logic [3:0] ST_RQ   = 4'd11;
	localparam logic [3:0] ST_RQW  = 4'd12;
	localparam logic [3:0] ST_OUT  = 4'd13;

	logic [3:0]  state_q;
	logic [1:0]  func_q;
	logic [15:0] value_q;
	logic [1:0]  word_idx_q;
	logic        rnd_q;
	logic [15:0] ring_degree_q;
	logic [15:0] modulus_q;
	logic [7:0]  coeff_bound_q;
	logic [63:0] sponge_q;
	logic [16:0] limit_q;
	logic [63:0] z_q;
	logic [63:0] lo_q;
	logic [31:0] hi_q;
	logic [15:0] t_q;
	logic [9:0]  e_q;
	logic        res_valid_q;
	logic [8:0]  small_q;
	logic [15:0] residue_q;

	mul_op_t     mul_op;
	logic [63:0] mul_p;
	rem_req_t    rem_req;
	rem_rsp_t    rem_rsp;

	logic [31:0] absorb_v;
	logic [31:0] absorb_lane;
	logic [63:0] mix_c;
	logic [63:0] prep_base;
	logic [31:0] hsum;
	logic [63:0] mix_y;
	logic [63:0] mix_out;
	logic [8:0]  m_val;
	logic [16:0] q_eff;
	logic [9:0]  e_new;
	logic [7:0]  e_mag;
	logic [16:0] res_new;
	logic        item_acc;
	logic        res_free;
	logic        res_load;

	hspl_mul32 u_mul (
		.clk  (clk),
		.op   (mul_op),
		.prod (mul_p)
	);

	hspl_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	assign item.ready = (state_q == ST_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign cfg.ready  = 1'b1;
	assign res_free   = !res_valid_q || result.ready;
	assign res_load   = (state_q == ST_OUT) && res_free;

	assign m_val = {coeff_bound_q, 1'b1};
	assign q_eff = (modulus_q == 16'd0) ? WORD_SPAN : {1'b0, modulus_q};

	always_comb begin
		case (func_q)
			FUNC_START: begin
				absorb_lane = LANE_WORD;
				case (word_idx_q)
					2'd0:    absorb_v = TAG_WORD;
					2'd1:    absorb_v = {16'd0, ring_degree_q};
					2'd2:    absorb_v = {16'd0, modulus_q};
					default: absorb_v = {24'd0, coeff_bound_q};
				endcase
			end
			FUNC_COEFF: begin
				absorb_lane = LANE_COEFF;
				absorb_v    = {16'd0, value_q};
			end
			default: begin
				absorb_lane = LANE_BYTE;
				absorb_v    = {24'd0, value_q[7:0]};
			end
		endcase
	end

	assign mix_c = rnd_q ? MIX_C2 : MIX_C1;

	always_comb begin
		case (state_q)
			ST_MULV: mul_op = '{a: absorb_v, b: absorb_lane};
			ST_M0:   mul_op = '{a: z_q[31:0], b: mix_c[31:0]};
			ST_M1:   mul_op = '{a: z_q[31:0], b: mix_c[63:32]};
			ST_M2:   mul_op = '{a: z_q[63:32], b: mix_c[31:0]};
			default: mul_op = '{a: 32'd0, b: 32'd0};
		endcase
	end

	assign prep_base = ((func_q == FUNC_DRAW) ? sponge_q : (sponge_q ^ mul_p)) + GOLDEN_GAMMA;
	assign hsum      = hi_q + mul_p[31:0];
	assign mix_y     = lo_q + {hsum, 32'd0};
	assign mix_out   = mix_y ^ (mix_y >> 31);

	assign e_new   = {1'b0, rem_rsp.remainder[8:0]} - {2'b00, coeff_bound_q};
	assign e_mag   = e_q[9] ? 8'(-e_q) : e_q[7:0];
	assign res_new = e_q[9] ? ((rem_rsp.remainder == '0) ? 17'd0 : q_eff - rem_rsp.remainder)
	                        : rem_rsp.remainder;

	always_comb begin
		rem_req = '{go: 1'b0, dividend: '0, divisor: '0};
		case (state_q)
			ST_LIM: rem_req = '{go: 1'b1, dividend: WORD_SPAN, divisor: {8'd0, m_val}};
			ST_RM:  rem_req = '{go: 1'b1, dividend: {1'b0, t_q}, divisor: {8'd0, m_val}};
			ST_RQ:  rem_req = '{go: 1'b1, dividend: {9'd0, e_mag}, divisor: q_eff};
			default: rem_req = '{go: 1'b0, dividend: '0, divisor: '0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_degree_q <= RING_DEGREE_RST;
			modulus_q     <= MODULUS_RST;
			coeff_bound_q <= COEFF_BOUND_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_RING_DEGREE: ring_degree_q <= cfg.data;
				CFG_MODULUS:     modulus_q     <= cfg.data;
				CFG_COEFF_BOUND: coeff_bound_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			func_q      <= FUNC_START;
			word_idx_q  <= 2'd0;
			rnd_q       <= 1'b0;
			sponge_q    <= SEED_WORD;
			limit_q     <= LIMIT_RST;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						func_q     <= item.func;
						word_idx_q <= 2'd0;
						if (item.func == FUNC_START) begin
							sponge_q <= SEED_WORD;
						end
						state_q <= (item.func == FUNC_DRAW) ? ST_PREP : ST_MULV;
					end
				end
				ST_MULV: state_q <= ST_PREP;
				ST_PREP: begin
					if (func_q == FUNC_DRAW) begin
						sponge_q <= prep_base;
					end
					rnd_q   <= 1'b0;
					state_q <= ST_M0;
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: begin
					if (!rnd_q) begin
						rnd_q   <= 1'b1;
						state_q <= ST_M0;
					end else if (func_q == FUNC_DRAW) begin
						state_q <= ({1'b0, mix_out[15:0]} < limit_q) ? ST_RM : ST_PREP;
					end else begin
						sponge_q <= mix_out;
						if (func_q != FUNC_START) begin
							state_q <= ST_IDLE;
						end else if (word_idx_q == 2'd3) begin
							state_q <= ST_LIM;
						end else begin
							word_idx_q <= word_idx_q + 2'd1;
							state_q    <= ST_MULV;
						end
					end
				end
				ST_LIM: state_q <= ST_LIMW;
				ST_LIMW: begin
					if (rem_rsp.done) begin
						limit_q <= WORD_SPAN - rem_rsp.remainder;
						state_q <= ST_IDLE;
					end
				end
				ST_RM:  state_q <= ST_RMW;
				ST_RMW: begin
					if (rem_rsp.done) begin
						state_q <= ST_RQ;
					end
				end
				ST_RQ:  state_q <= ST_RQW;
				ST_RQW: begin
					if (rem_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			value_q <= item.value;
		end
		if (state_q == ST_PREP) begin
			z_q <= prep_base ^ (prep_base >> 30);
		end
		if (state_q == ST_M3 && !rnd_q) begin
			z_q <= mix_y ^ (mix_y >> 27);
		end
		if (state_q == ST_M1) begin
			lo_q <= mul_p;
		end
		if (state_q == ST_M2) begin
			hi_q <= mul_p[31:0];
		end
		if (state_q == ST_M3 && rnd_q) begin
			t_q <= mix_out[15:0];
		end
		if (state_q == ST_RMW && rem_rsp.done) begin
			e_q <= e_new;
		end
		if (res_load) begin
			small_q   <= e_q[8:0];
			residue_q <= res_new[15:0];
		end
	end

	assign result.valid         = res_valid_q;
	assign result.small_coeff   = small_q;
	assign result.residue_coeff = residue_q;

	a_rem_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rem_req.go |-> !rem_rsp.busy)
		else $error("remainder unit started while busy");

	a_res_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside output state");

	a_small_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (e_mag <= coeff_bound_q))
		else $error("coefficient outside bound");

	a_residue_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> ({1'b0, residue_q} < q_eff))
		else $error("residue not reduced");

endmodule

// File: rtl/core/hspl_mul32.sv
// Shared 32x32 multiplier with registered 64-bit product.
// Depends on hspl_pkg.
`timescale 1ns / 1ps

module hspl_mul32 import hspl_pkg::*; (
	input  logic        clk,
	input  mul_op_t     op,
	output logic [63:0] prod
);

	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 64'(op.a) * 64'(op.b);
	end

	assign prod = prod_q;

endmodule

// File: rtl/core/hspl_rem.sv
// Restoring remainder unit, one dividend bit per cycle.
// Depends on hspl_pkg.
`timescale 1ns / 1ps

module hspl_rem import hspl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rem_req_t req,
	output rem_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [REM_CW-1:0] cnt_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  dvd_q;
	logic [REM_W-1:0]  dvs_q;
	logic [REM_W:0]    trial;
	logic [REM_W:0]    diff;

	assign trial = {rem_q, dvd_q[REM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == REM_CW'(REM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[REM_W-2:0], 1'b0};
			if (!diff[REM_W]) begin
				rem_q <= diff[REM_W-1:0];
			end else begin
				rem_q <= trial[REM_W-1:0];
			end
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

// File: test/testbench.sv
// Testbench for hash_to_small_poly_sampler: drives start, absorb and draw items with
// random pacing, predicts each sampled coefficient and its residue, checks every result.
// Depends on hspl_pkg, the hspl channel interfaces and the sampler RTL.
`timescale 1ns / 1ps

module testbench;
	import hspl_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES   = 600;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  func;
		logic [15:0] value;
	} item_t;

	typedef struct {
		logic [8:0]  coeff;
		logic [15:0] residue;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n;

	hspl_item_if item_ch();
	hspl_res_if  res_ch();
	hspl_cfg_if  cfg_ch();

	hash_to_small_poly_sampler dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [63:0] sponge = SEED_WORD;
	logic [16:0] latched_limit = 17'd65535;
	logic [15:0] cfg_degree = 16'd509;
	logic [15:0] cfg_modulus = 16'd2048;
	logic [7:0]  cfg_bound = 8'd1;

	item_t   items_todo[$];
	sample_t coeff_due[$];
	item_t   next_item;

	int  mismatches = 0;
	int  items_in = 0;
	int  cycles = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	int  hold_at = -1;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  pace_on = 1'b1;

	function automatic logic [63:0] mix_word(input logic [63:0] z);
		z = (z ^ (z >> 30)) * MIX_C1;
		z = (z ^ (z >> 27)) * MIX_C2;
		return z ^ (z >> 31);
	endfunction

	function automatic void absorb_word(input logic [31:0] v, input logic [31:0] lane);
		logic [63:0] prod;
		prod = {32'd0, v} * {32'd0, lane};
		sponge = mix_word((sponge ^ prod) + GOLDEN_GAMMA);
	endfunction

	function automatic logic [16:0] limit_for_bound(input logic [7:0] b);
		int unsigned m;
		m = 2 * b + 1;
		return 17'((65536 / m) * m);
	endfunction

	function automatic void predict_item(input logic [1:0] fn, input logic [15:0] val);
		int unsigned m, lim, t, q, r;
		int e;
		logic [63:0] mixed;
		sample_t s;
		case (fn)
		FUNC_START: begin
			sponge = SEED_WORD;
			absorb_word(TAG_WORD, LANE_WORD);
			absorb_word({16'd0, cfg_degree}, LANE_WORD);
			absorb_word({16'd0, cfg_modulus}, LANE_WORD);
			absorb_word({24'd0, cfg_bound}, LANE_WORD);
			latched_limit = limit_for_bound(cfg_bound);
		end
		FUNC_COEFF: begin
			absorb_word({16'd0, val}, LANE_COEFF);
		end
		FUNC_BYTE: begin
			absorb_word({24'd0, val[7:0]}, LANE_BYTE);
		end
		FUNC_DRAW: begin
			m = 2 * cfg_bound + 1;
			lim = (latched_limit == 0) ? 1 : latched_limit;
			do begin
				sponge = sponge + GOLDEN_GAMMA;
				mixed = mix_word(sponge);
				t = 32'(mixed[15:0]);
			end while (t >= lim);
			e = int'(t % m) - int'(cfg_bound);
			q = (cfg_modulus == 0) ? 65536 : cfg_modulus;
			if (e >= 0) begin
				r = unsigned'(e) % q;
			end else begin
				r = unsigned'(-e) % q;
				if (r != 0) r = q - r;
			end
			s.coeff = e[8:0];
			s.residue = r[15:0];
			coeff_due.push_back(s);
		end
		endcase
	endfunction

	function automatic void check_result(input logic [8:0] got_coeff, input logic [15:0] got_res);
		sample_t want;
		bit bad;
		if (coeff_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: coeff %0d residue %0d",
					$signed(got_coeff), got_res);
			return;
		end
		want = coeff_due.pop_front();
		bad = 1'b0;
		if (got_coeff !== want.coeff) bad = 1'b1;
		if (got_res !== want.residue) bad = 1'b1;
		if (bad) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: coeff %0d residue %0d, expected coeff %0d residue %0d",
					$signed(got_coeff), got_res, $signed(want.coeff), want.residue);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 90);
	endfunction

	// item driver
	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				predict_item(item_ch.func, item_ch.value);
				items_in <= items_in + 1;
				send_gap = pace_on ? pick_gap() : 0;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_ch.valid <= 1'b0;
				end else if (items_todo.size() > 0) begin
					next_item = items_todo.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.func <= next_item.func;
					item_ch.value <= next_item.value;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				check_result(res_ch.small_coeff, res_ch.residue_coeff);
			if (hold_left != 0) begin
				res_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if (pace_on && $urandom_range(0, 7) == 0) recv_gap = pick_gap();
			end
		end
	end

	// long receiver hold-off, started once the item count reaches hold_at
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && items_in == hold_at) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_item(input logic [1:0] fn, input logic [15:0] val);
		item_t it;
		it.func = fn;
		it.value = val;
		items_todo.push_back(it);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
		CFG_RING_DEGREE: cfg_degree = val;
		CFG_MODULUS:     cfg_modulus = val;
		CFG_COEFF_BOUND: cfg_bound = val[7:0];
		CFG_UNUSED:      ;
		endcase
		@(negedge clk);
	endtask

	// wait for the block to go quiet, including items that leave no result
	task automatic settle();
		do @(negedge clk);
		while (items_todo.size() != 0 || item_ch.valid || coeff_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_batch(input int count);
		int n, k;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_item(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
				n++;
			end else begin
				queue_item(FUNC_START, 16'($urandom_range(0, 65535)));
				n++;
				k = $urandom_range(0, 6);
				repeat (k) begin
					queue_item($urandom_range(0, 1) ? FUNC_COEFF : FUNC_BYTE,
						16'($urandom_range(0, 65535)));
					n++;
				end
				k = $urandom_range(1, 5);
				repeat (k) begin
					queue_item(FUNC_DRAW, 16'($urandom_range(0, 65535)));
					n++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.func = FUNC_START;
		item_ch.value = 16'd0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_RING_DEGREE;
		cfg_ch.data = 16'd0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, draws before any start
		queue_item(FUNC_DRAW, 16'h0000);
		queue_item(FUNC_DRAW, 16'hFFFF);
		queue_item(FUNC_START, 16'hFFFF);
		queue_item(FUNC_COEFF, 16'h0000);
		queue_item(FUNC_COEFF, 16'hFFFF);
		queue_item(FUNC_BYTE, 16'h0000);
		queue_item(FUNC_BYTE, 16'hFFFF);
		queue_item(FUNC_DRAW, 16'h0000);
		queue_item(FUNC_DRAW, 16'h5555);
		queue_item(FUNC_START, 16'h0000);
		queue_item(FUNC_BYTE, 16'hAA5A);
		settle();

		// widest header, modulus zero, largest bound
		write_reg(CFG_RING_DEGREE, 16'hFFFF);
		write_reg(CFG_MODULUS, 16'h0000);
		write_reg(CFG_COEFF_BOUND, 16'h00FF);
		queue_item(FUNC_START, 16'h1234);
		queue_item(FUNC_COEFF, 16'h8000);
		queue_item(FUNC_DRAW, 16'h0000);
		queue_item(FUNC_DRAW, 16'hFFFF);
		queue_item(FUNC_DRAW, 16'h0F0F);
		settle();

		// modulus one, zero bound, unused register index
		write_reg(CFG_MODULUS, 16'h0001);
		write_reg(CFG_COEFF_BOUND, 16'h0000);
		write_reg(CFG_RING_DEGREE, 16'h0000);
		write_reg(CFG_UNUSED, 16'hFFFF);
		queue_item(FUNC_START, 16'h0000);
		queue_item(FUNC_DRAW, 16'h0000);
		queue_item(FUNC_DRAW, 16'h0000);
		settle();

		// bound changed after start: draws keep the latched limit
		write_reg(CFG_COEFF_BOUND, 16'hFFC8);
		queue_item(FUNC_DRAW, 16'h0000);
		queue_item(FUNC_DRAW, 16'h0000);
		settle();

		// random sequences, no idling
		pace_on = 1'b0;
		write_reg(CFG_RING_DEGREE, 16'($urandom_range(1, 65535)));
		write_reg(CFG_MODULUS, 16'($urandom_range(2, 65535)));
		write_reg(CFG_COEFF_BOUND, 16'($urandom_range(1, 255)));
		run_batch(100);
		settle();

		// modulus two, bound one, ring degree one, with a long receiver hold-off
		pace_on = 1'b1;
		write_reg(CFG_RING_DEGREE, 16'd1);
		write_reg(CFG_MODULUS, 16'd2);
		write_reg(CFG_COEFF_BOUND, 16'd1);
		hold_at = items_in + 30;
		run_batch(100);
		settle();

		// largest settings
		write_reg(CFG_RING_DEGREE, 16'hFFFF);
		write_reg(CFG_MODULUS, 16'hFFFF);
		write_reg(CFG_COEFF_BOUND, 16'h00FF);
		run_batch(100);
		settle();

		// small modulus against wide bounds
		write_reg(CFG_MODULUS, 16'($urandom_range(2, 40)));
		write_reg(CFG_COEFF_BOUND, 16'($urandom_range(100, 255)));
		run_batch(100);
		settle();

		// anything the fields allow
		write_reg(CFG_RING_DEGREE, 16'($urandom_range(0, 65535)));
		write_reg(CFG_MODULUS, 16'($urandom_range(0, 65535)));
		write_reg(CFG_COEFF_BOUND, 16'($urandom_range(0, 65535)));
		run_batch(100);
		settle();

		if (mismatches == 0 && coeff_due.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/hspl_pkg.sv
rtl/core/hspl_if.sv
rtl/core/hspl_mul32.sv
rtl/core/hspl_rem.sv
rtl/core/hash_to_small_poly_sampler.sv
test/testbench.sv
